@@ hdl/vchb_pkg.sv @@
`timescale 1ns / 1ps

package vchb_pkg;

   // Field widths fixed by the interface
   localparam int CMD_W    = 2;
   localparam int VALUE_W  = 12;
   localparam int MULT_W   = 20;
   localparam int PERIOD_W = 16;
   localparam int SPEED_W  = 7;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = MULT_W;

   // Widest sample the store can be built for
   localparam int SAMPLE_EXT_W = 16;

   // Dividend width: multiplier times speed target
   localparam int DVD_W     = MULT_W + SPEED_W;
   localparam int DIV_CNT_W = $clog2(DVD_W);

   // Parameter defaults
   localparam int SCAN_LENGTH_DEF = 2;
   localparam int SAMPLE_BITS_DEF = 12;

   // Register reset values
   localparam logic [MULT_W-1:0]   MULT_RESET   = MULT_W'(102350);
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(4199);

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MULT   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD = 1'b1;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_SAMPLE    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SPEED     = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DIRECTION = 2'd2;
   localparam logic [CMD_W-1:0] CMD_START     = 2'd3;

   // Special speed steps
   localparam logic [SPEED_W-1:0] SPEED_STOP  = 7'd0;
   localparam logic [SPEED_W-1:0] SPEED_ESTOP = 7'd1;
   localparam logic [SPEED_W-1:0] SPEED_MAX   = 7'd127;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [VALUE_W-1:0] value;
   } req_payload_type;

   typedef struct packed {
      logic [PERIOD_W-1:0] compare_a;
      logic [PERIOD_W-1:0] compare_b;
      logic                scan_request;
      logic                halted;
   } rsp_payload_type;

   // Controller to datapath
   typedef struct packed {
      logic load_item;
      logic exec;
      logic div_step;
      logic div_finish;
      logic emit;
   } vchb_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic need_div;
   } vchb_status_type;

endpackage

@@ hdl/vchb_ctrl.sv @@
`timescale 1ns / 1ps

module vchb_ctrl
   import vchb_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output vchb_cmd_type    ctl,
   input  vchb_status_type sts
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EXEC = 3'd1;
   localparam logic [2:0] S_DIV  = 3'd2;
   localparam logic [2:0] S_FIN  = 3'd3;
   localparam logic [2:0] S_EMIT = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 slot_free;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ctl          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl.load_item = 1'b1;
               state_in      = S_EXEC;
            end
         end
         S_EXEC: begin
            ctl.exec = 1'b1;
            if (sts.need_div) begin
               cnt_in   = DIV_CNT_W'(DVD_W - 1);
               state_in = S_DIV;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_DIV: begin
            ctl.div_step = 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_FIN;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         S_FIN: begin
            ctl.div_finish = 1'b1;
            state_in       = S_EMIT;
         end
         S_EMIT: begin
            if (slot_free) begin
               ctl.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ hdl/vchb_dp.sv @@
`timescale 1ns / 1ps

module vchb_dp
   import vchb_pkg::*;
#(
   parameter int SCAN_LENGTH = SCAN_LENGTH_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  req_payload_type       req_payload,
   input  vchb_cmd_type          ctl,
   output vchb_status_type       sts,
   output rsp_payload_type       rsp_payload
);

   localparam int POS_W = $clog2(SCAN_LENGTH + 1);
   localparam int IDX_W = (SCAN_LENGTH > 1) ? $clog2(SCAN_LENGTH) : 1;

   // Configuration
   logic [MULT_W-1:0]   mult_ff, mult_in;
   logic [PERIOD_W-1:0] period_ff, period_in;

   // Control state
   logic [SAMPLE_BITS-1:0] last_ff [SCAN_LENGTH];
   logic [SAMPLE_BITS-1:0] last_in [SCAN_LENGTH];
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic [SPEED_W-1:0]     speed_ff, speed_in;
   logic                   reverse_ff, reverse_in;
   logic                   stopped_ff, stopped_in;
   logic [PERIOD_W-1:0]    duty_ff, duty_in;
   logic [PERIOD_W-1:0]    out_a_ff, out_a_in;
   logic [PERIOD_W-1:0]    out_b_ff, out_b_in;
   logic                   request_ff, request_in;

   // Item and divider payload
   logic [CMD_W-1:0]       cmd_ff, cmd_in;
   logic [VALUE_W-1:0]     value_ff, value_in;
   logic [DVD_W-1:0]       quo_ff, quo_in;
   logic [SAMPLE_BITS-1:0] rem_ff, rem_in;
   logic [SAMPLE_BITS-1:0] divisor_ff, divisor_in;
   rsp_payload_type        rsp_ff, rsp_in;

   // Decode helpers
   logic [SAMPLE_EXT_W-1:0] value_ext;
   logic [SAMPLE_BITS-1:0]  sample;
   logic [IDX_W-1:0]        pos_idx;
   logic                    in_scan;
   logic                    differs;
   logic                    upd_duty;
   logic                    scan_idle;
   logic [SPEED_W-1:0]      speed_sat;
   logic                    dir_new;
   logic [SPEED_W-1:0]      target;
   logic [DVD_W-1:0]        product;
   logic [SAMPLE_BITS:0]    trial;
   logic [SAMPLE_BITS:0]    trial_diff;
   logic                    trial_ge;
   logic [PERIOD_W-1:0]     duty_sat;

   assign value_ext = {{(SAMPLE_EXT_W - VALUE_W){1'b0}}, value_ff};
   assign sample    = value_ext[SAMPLE_BITS-1:0];
   assign pos_idx   = pos_ff[IDX_W-1:0];
   assign in_scan   = (pos_ff < POS_W'(SCAN_LENGTH));
   assign scan_idle = !in_scan;
   assign differs   = in_scan && (last_ff[pos_idx] != sample);
   assign upd_duty  = differs && !stopped_ff && (pos_ff == '0);
   assign speed_sat = (value_ff > VALUE_W'(SPEED_MAX)) ? SPEED_MAX : value_ff[SPEED_W-1:0];
   assign dir_new   = (value_ff != '0);
   assign target    = (speed_ff == SPEED_STOP) ? '0 : speed_ff - 1'b1;
   assign product   = DVD_W'(mult_ff) * DVD_W'(target);

   assign sts.need_div = (cmd_ff == CMD_SAMPLE) && upd_duty && (sample != '0);

   // One restoring divide step
   assign trial      = {rem_ff, quo_ff[DVD_W-1]};
   assign trial_diff = trial - {1'b0, divisor_ff};
   assign trial_ge   = (trial >= {1'b0, divisor_ff});

   // Saturate the quotient at the period
   assign duty_sat = (quo_ff > DVD_W'(period_ff)) ? period_ff : quo_ff[PERIOD_W-1:0];

   assign rsp_payload = rsp_ff;

   always_comb begin
      mult_in    = mult_ff;
      period_in  = period_ff;
      last_in    = last_ff;
      pos_in     = pos_ff;
      speed_in   = speed_ff;
      reverse_in = reverse_ff;
      stopped_in = stopped_ff;
      duty_in    = duty_ff;
      out_a_in   = out_a_ff;
      out_b_in   = out_b_ff;
      request_in = request_ff;
      cmd_in     = cmd_ff;
      value_in   = value_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      rsp_in     = rsp_ff;

      // Configuration writes
      if (csr_we) begin
         unique case (csr_index)
            CSR_MULT:   mult_in   = csr_wdata[MULT_W-1:0];
            CSR_PERIOD: period_in = csr_wdata[PERIOD_W-1:0];
            default:    ;
         endcase
      end

      // Latch the incoming transaction
      if (ctl.load_item) begin
         cmd_in   = req_payload.cmd;
         value_in = req_payload.value;
      end

      // Apply the command
      if (ctl.exec) begin
         request_in = 1'b0;
         unique case (cmd_ff)
            CMD_SAMPLE: begin
               if (differs) begin
                  last_in[pos_idx] = sample;
               end
               if (in_scan) begin
                  pos_in = pos_ff + 1'b1;
               end
               // Zero voltage drives the full period right away
               if (upd_duty && (sample == '0)) begin
                  duty_in  = period_ff;
                  out_a_in = reverse_ff ? '0 : period_ff;
                  out_b_in = reverse_ff ? period_ff : '0;
               end
               quo_in     = product;
               rem_in     = '0;
               divisor_in = sample;
            end
            CMD_SPEED: begin
               if (speed_sat != speed_ff) begin
                  speed_in = speed_sat;
                  if (speed_sat == SPEED_STOP) begin
                     if (!stopped_ff) begin
                        stopped_in = 1'b1;
                        out_a_in   = '0;
                        out_b_in   = '0;
                     end
                  end else if (speed_sat == SPEED_ESTOP) begin
                     if (!stopped_ff) begin
                        stopped_in = 1'b1;
                        out_a_in   = period_ff;
                        out_b_in   = period_ff;
                     end
                  end else if (scan_idle) begin
                     pos_in     = '0;
                     request_in = 1'b1;
                  end
               end
            end
            CMD_DIRECTION: begin
               if (dir_new != reverse_ff) begin
                  reverse_in = dir_new;
                  out_a_in   = dir_new ? '0 : duty_ff;
                  out_b_in   = dir_new ? duty_ff : '0;
               end
            end
            CMD_START: begin
               if (stopped_ff) begin
                  stopped_in = 1'b0;
                  if (scan_idle) begin
                     pos_in     = '0;
                     request_in = 1'b1;
                  end
               end
            end
            default: ;
         endcase
      end

      // Divider iteration
      if (ctl.div_step) begin
         rem_in = trial_ge ? trial_diff[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
         quo_in = {quo_ff[DVD_W-2:0], trial_ge};
      end

      // Commit the new duty
      if (ctl.div_finish) begin
         duty_in  = duty_sat;
         out_a_in = reverse_ff ? '0 : duty_sat;
         out_b_in = reverse_ff ? duty_sat : '0;
      end

      // Output register
      if (ctl.emit) begin
         rsp_in.compare_a    = out_a_ff;
         rsp_in.compare_b    = out_b_ff;
         rsp_in.scan_request = request_ff;
         rsp_in.halted       = stopped_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mult_ff    <= MULT_RESET;
         period_ff  <= PERIOD_RESET;
         for (int i = 0; i < SCAN_LENGTH; i++) begin
            last_ff[i] <= '0;
         end
         pos_ff     <= POS_W'(SCAN_LENGTH);
         speed_ff   <= SPEED_STOP;
         reverse_ff <= 1'b0;
         stopped_ff <= 1'b0;
         duty_ff    <= '0;
         out_a_ff   <= '0;
         out_b_ff   <= '0;
         request_ff <= 1'b0;
      end else begin
         mult_ff    <= mult_in;
         period_ff  <= period_in;
         last_ff    <= last_in;
         pos_ff     <= pos_in;
         speed_ff   <= speed_in;
         reverse_ff <= reverse_in;
         stopped_ff <= stopped_in;
         duty_ff    <= duty_in;
         out_a_ff   <= out_a_in;
         out_b_ff   <= out_b_in;
         request_ff <= request_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      value_ff   <= value_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      rsp_ff     <= rsp_in;
   end

endmodule

@@ hdl/voltage_compensated_hbridge_pwm.sv @@
`timescale 1ns / 1ps
// Channel   Ports                                 Direction
// ------    ------------------------------------  ---------
// request   req_valid, req_stall, req_payload     in
// response  rsp_valid, rsp_stall, rsp_payload     out
// csr       csr_we, csr_index, csr_wdata          in
//
// One transaction at a time. Speed, direction and start commands, and samples
// that need no divide, go from acceptance through execute to emit, where
// rsp_valid is registered; a nonzero track-voltage sample that changes the
// duty adds the divide and finish states, run by the bit-serial divider (one
// quotient bit per cycle over the 27-bit product).
// Synchronous active-high reset; no clearing pass is needed.
// A response waiting under rsp_stall holds in its register while the next
// transaction is accepted; that transaction completes once the slot frees.

module voltage_compensated_hbridge_pwm
   import vchb_pkg::*;
#(
   parameter int SCAN_LENGTH = SCAN_LENGTH_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_payload_type       req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_payload,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   vchb_cmd_type    ctl;
   vchb_status_type sts;

   vchb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctl       (ctl),
      .sts       (sts)
   );

   vchb_dp #(
      .SCAN_LENGTH (SCAN_LENGTH),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_payload (req_payload),
      .ctl         (ctl),
      .sts         (sts),
      .rsp_payload (rsp_payload)
   );

endmodule

@@ bench/tb_voltage_compensated_hbridge_pwm.sv @@
`timescale 1ns / 1ps

module tb_voltage_compensated_hbridge_pwm
   import vchb_pkg::*;
();

   localparam int SCAN_LEN      = SCAN_LENGTH_DEF;
   localparam int TRACK_CH      = 0;
   localparam int SETTLE_CYCLES = 40;
   localparam int STALL_LIMIT   = 4000;  // cycles without any transaction
   localparam int LONG_HOLD     = 200;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_payload_type       req_payload;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_payload_type       rsp_payload;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   voltage_compensated_hbridge_pwm u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   // Bridge state as the block should hold it
   logic [VALUE_W-1:0]  stored_samples [SCAN_LEN];
   int                  scan_pos;
   logic [SPEED_W-1:0]  speed_q;
   logic                reverse_q;
   logic                stopped_q;
   logic [PERIOD_W-1:0] duty_q;
   logic [PERIOD_W-1:0] cmp_a_q;
   logic [PERIOD_W-1:0] cmp_b_q;
   logic [MULT_W-1:0]   mult_q;
   logic [PERIOD_W-1:0] period_q;

   rsp_payload_type expected_rsps [$];

   int  error_count  = 0;
   int  items_sent   = 0;
   int  results_seen = 0;
   int  config_writes = 0;
   int  scans_started = 0;
   int  halts_entered = 0;
   int  idle_cycles  = 0;
   bit  gaps_on      = 0;
   bit  stalls_on    = 0;
   int  hold_cycles  = 0;

   // Clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------
   function automatic logic [PERIOD_W-1:0] duty_for(input logic [VALUE_W-1:0] smp);
      longint unsigned target;
      longint unsigned q;
      target = (speed_q != '0) ? 64'(speed_q) - 64'd1 : 64'd0;
      if (smp == '0)
         return period_q;
      q = (64'(mult_q) * target) / 64'(smp);
      if (q > 64'(period_q))
         q = 64'(period_q);
      return q[PERIOD_W-1:0];
   endfunction

   function automatic void route_duty();
      if (!reverse_q) begin
         cmp_a_q = duty_q;
         cmp_b_q = '0;
      end else begin
         cmp_a_q = '0;
         cmp_b_q = duty_q;
      end
   endfunction

   // A scan only starts when the previous sequence has finished
   function automatic logic open_scan();
      if (scan_pos >= SCAN_LEN) begin
         scan_pos = 0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic predict_bridge(input req_payload_type item);
      logic [SPEED_W-1:0] spd;
      logic               dir;
      logic               scan_req;
      rsp_payload_type    r;
      scan_req = 1'b0;
      case (item.cmd)
         CMD_SAMPLE: begin
            if (scan_pos < SCAN_LEN) begin
               if (stored_samples[scan_pos] != item.value) begin
                  stored_samples[scan_pos] = item.value;
                  if (!stopped_q && scan_pos == TRACK_CH) begin
                     duty_q = duty_for(item.value);
                     route_duty();
                  end
               end
               scan_pos++;
            end
         end
         CMD_SPEED: begin
            spd = (item.value > SPEED_MAX) ? SPEED_MAX : item.value[SPEED_W-1:0];
            if (spd != speed_q) begin
               speed_q = spd;
               if (spd == SPEED_STOP) begin
                  if (!stopped_q) begin
                     stopped_q = 1'b1;
                     cmp_a_q   = '0;
                     cmp_b_q   = '0;
                     halts_entered++;
                  end
               end else if (spd == SPEED_ESTOP) begin
                  if (!stopped_q) begin
                     stopped_q = 1'b1;
                     cmp_a_q   = period_q;
                     cmp_b_q   = period_q;
                     halts_entered++;
                  end
               end else begin
                  scan_req = open_scan();
               end
            end
         end
         CMD_DIRECTION: begin
            dir = (item.value != 0);
            if (dir != reverse_q) begin
               reverse_q = dir;
               route_duty();
            end
         end
         CMD_START: begin
            if (stopped_q) begin
               stopped_q = 1'b0;
               scan_req  = open_scan();
            end
         end
      endcase
      if (scan_req)
         scans_started++;
      r.compare_a    = cmp_a_q;
      r.compare_b    = cmp_b_q;
      r.scan_request = scan_req;
      r.halted       = stopped_q;
      expected_rsps.push_back(r);
   endtask

   // ---------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------
   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      error_count++;
      // keep the log readable when the block is badly broken
      if (error_count <= 50)
         $display("%0t ns: %s got %0h, expected %0h", $realtime, what, got, want);
   endtask

   always @(posedge clock) begin : check_rsp
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_rsps.size() == 0) begin
            report_mismatch("transaction with nothing pending", 1, 0);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_payload.compare_a !== want.compare_a)
               report_mismatch("compare_a", 32'(rsp_payload.compare_a),
                               32'(want.compare_a));
            if (rsp_payload.compare_b !== want.compare_b)
               report_mismatch("compare_b", 32'(rsp_payload.compare_b),
                               32'(want.compare_b));
            if (rsp_payload.scan_request !== want.scan_request)
               report_mismatch("scan_request", 32'(rsp_payload.scan_request),
                               32'(want.scan_request));
            if (rsp_payload.halted !== want.halted)
               report_mismatch("halted", 32'(rsp_payload.halted), 32'(want.halted));
         end
      end
   end

   // Watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
         $display("simulation failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Response side: random stall bursts and the long hold-off
   // ---------------------------------------------------------------
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_stall = 1'b1;
            repeat (hold_cycles) @(negedge clock);
            hold_cycles = 0;
            rsp_stall   = 1'b0;
         end else if (stalls_on && $urandom_range(0, 7) == 0) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 14)) @(negedge clock);
            rsp_stall = 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------
   task automatic send_item(input logic [CMD_W-1:0] cmd, input int unsigned value);
      req_payload_type item;
      item.cmd   = cmd;
      item.value = value[VALUE_W-1:0];
      if (gaps_on && $urandom_range(0, 7) == 0)
         repeat ($urandom_range(1, 14)) @(negedge clock);
      req_payload = item;
      req_valid   = 1'b1;
      do @(posedge clock); while (req_stall);
      predict_bridge(item);
      items_sent++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // Pause until every outstanding transaction has come back
   task automatic wait_drained();
      while (expected_rsps.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 1'b0;
      if (idx == CSR_MULT)
         mult_q = data;
      else
         period_q = data[PERIOD_W-1:0];
      config_writes++;
   endtask

   task automatic set_bridge_config(input int unsigned mult, input int unsigned period);
      wait_drained();
      write_reg(CSR_MULT, CSR_DATA_W'(mult));
      write_reg(CSR_PERIOD, CSR_DATA_W'(period));
   endtask

   // Speed change followed by one full scan sequence
   task automatic run_scan_cycle(input int unsigned spd, input int unsigned track,
                                 input int unsigned aux);
      send_item(CMD_SPEED, spd);
      send_item(CMD_SAMPLE, track);
      send_item(CMD_SAMPLE, aux);
   endtask

   function automatic int unsigned pick_track_sample();
      case ($urandom_range(0, 7))
         0:       return 0;
         1:       return 32'(stored_samples[TRACK_CH]);
         2:       return $urandom_range(1, 15);
         3:       return 4095;
         default: return $urandom_range(0, 4095);
      endcase
   endfunction

   function automatic int unsigned pick_speed();
      case ($urandom_range(0, 9))
         0:       return $urandom_range(128, 4095);
         1:       return 32'(speed_q);
         default: return $urandom_range(2, 127);
      endcase
   endfunction

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------
   task automatic test_directed_cases();
      send_item(CMD_SAMPLE, 123);        // no scan running: ignored
      send_item(CMD_START, 0);           // running already
      send_item(CMD_DIRECTION, 0);       // unchanged direction
      send_item(CMD_SPEED, 1);           // emergency stop
      send_item(CMD_SPEED, 0);           // stop while stopped
      send_item(CMD_DIRECTION, 4095);    // swap while stopped
      send_item(CMD_START, 0);           // clears stop, opens a scan
      send_item(CMD_SPEED, 4095);        // saturates, scan already open
      send_item(CMD_SAMPLE, 4095);
      send_item(CMD_SAMPLE, 4095);
      send_item(CMD_SPEED, 127);         // unchanged speed
      run_scan_cycle(2, 0, 4095);        // zero voltage gives the period
      run_scan_cycle(3, 1, 2048);        // saturates at the period
      send_item(CMD_DIRECTION, 0);
      run_scan_cycle(50, 1500, 1500);
      send_item(CMD_SPEED, 0);           // stop: both sides low
      send_item(CMD_SPEED, 1);           // estop while stopped
      send_item(CMD_START, 0);
      send_item(CMD_DIRECTION, 1);
      send_item(CMD_SAMPLE, 700);        // estop speed gives zero duty
      send_item(CMD_SAMPLE, 5);
   endtask

   task automatic test_register_extremes();
      int unsigned mults   [5] = '{0, 1048575, 1048575, 1, 102350};
      int unsigned periods [5] = '{65535, 1, 65535, 0, 4199};
      for (int i = 0; i < 5; i++) begin
         set_bridge_config(mults[i], periods[i]);
         run_scan_cycle($urandom_range(2, 127), $urandom_range(1, 4095), 
                        $urandom_range(0, 4095));
         run_scan_cycle($urandom_range(2, 127), 0, $urandom_range(0, 4095));
         send_item(CMD_SPEED, 1);
         send_item(CMD_START, 0);
         send_item(CMD_SAMPLE, $urandom_range(1, 4095));
         send_item(CMD_SAMPLE, $urandom_range(0, 4095));
      end
   endtask

   task automatic test_backpressure();
      gaps_on     = 0;
      hold_cycles = LONG_HOLD;
      for (int i = 0; i < 6; i++)
         run_scan_cycle(pick_speed(), pick_track_sample(), $urandom_range(0, 4095));
      wait_drained();
      for (int i = 0; i < 3; i++)
         run_scan_cycle(pick_speed(), pick_track_sample(), $urandom_range(0, 4095));
   endtask

   task automatic random_scenario();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         run_scan_cycle(pick_speed(), pick_track_sample(), $urandom_range(0, 4095));
         if ($urandom_range(0, 9) == 0)
            send_item(CMD_SAMPLE, $urandom_range(0, 4095));   // past end of scan
      end else if (pick < 62) begin
         send_item(CMD_DIRECTION, $urandom_range(0, 1) ? 0 : $urandom_range(1, 4095));
      end else if (pick < 74) begin
         send_item(CMD_SPEED, $urandom_range(0, 1));
         if ($urandom_range(0, 1))
            send_item(CMD_DIRECTION, $urandom_range(0, 4095));
         send_item(CMD_START, $urandom_range(0, 4095));
         send_item(CMD_SAMPLE, pick_track_sample());
         send_item(CMD_SAMPLE, $urandom_range(0, 4095));
      end else if (pick < 82) begin
         send_item(CMD_START, $urandom_range(0, 4095));
      end else begin
         send_item(CMD_W'($urandom_range(0, 3)), $urandom_range(0, 4095));
      end
   endtask

   task automatic test_random_traffic();
      int chunk_end;
      for (int chunk = 0; chunk < 4; chunk++) begin
         case (chunk)
            0:       set_bridge_config(102350, 4199);
            1:       set_bridge_config($urandom_range(0, 1048575),
                                       $urandom_range(1, 65535));
            default: set_bridge_config($urandom_range(20000, 300000),
                                       $urandom_range(500, 9000));
         endcase
         gaps_on   = (chunk != 2);
         stalls_on = (chunk != 2);
         chunk_end = items_sent + 270;
         while (items_sent < chunk_end)
            random_scenario();
      end
   endtask

   task automatic test_unthrottled_tail();
      gaps_on   = 0;
      stalls_on = 0;
      set_bridge_config(102350, 4199);
      for (int i = 0; i < 30; i++)
         random_scenario();
   endtask

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      csr_we      = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;

      // predictor reset state
      foreach (stored_samples[i])
         stored_samples[i] = '0;
      scan_pos  = SCAN_LEN;
      speed_q   = '0;
      reverse_q = 1'b0;
      stopped_q = 1'b0;
      duty_q    = '0;
      cmp_a_q   = '0;
      cmp_b_q   = '0;
      mult_q    = MULT_RESET;
      period_q  = PERIOD_RESET;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      gaps_on   = 1;
      stalls_on = 1;
      test_directed_cases();
      test_register_extremes();
      test_backpressure();
      test_random_traffic();
      test_unthrottled_tail();

      // tail: everything back, then let the block settle
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("run covered %0d commands, %0d responses, %0d register writes",
               items_sent, results_seen, config_writes);
      $display("scans opened: %0d, stops entered: %0d, mismatches: %0d",
               scans_started, halts_entered, error_count);
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

@@ files.f @@
hdl/vchb_pkg.sv
hdl/vchb_ctrl.sv
hdl/vchb_dp.sv
hdl/voltage_compensated_hbridge_pwm.sv
bench/tb_voltage_compensated_hbridge_pwm.sv
